// ===== rtl/source_port_pool_allocator_core_defines.svh =====
// assertion macros shared by the allocator checker
`ifndef SOURCE_PORT_POOL_ALLOCATOR_CORE_DEFINES_SVH
`define SOURCE_PORT_POOL_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SPPA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

// next-cycle implication, checked outside reset
`define SPPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// ===== rtl/sppa_pkg.sv =====
// types, constants and codes of the source port pool allocator
package sppa_pkg;

  localparam int ADDR_MAX   = 4;
  localparam int PORT_MIN   = 1025;
  localparam int PORT_LIMIT = 65536;
  localparam int PORT_CNT   = (PORT_LIMIT > PORT_MIN) ? (PORT_LIMIT - PORT_MIN) : 0;

  localparam int AIDX_W  = (ADDR_MAX > 1) ? $clog2(ADDR_MAX) : 1;
  localparam int FIDX_W  = $clog2(ADDR_MAX + 1);
  localparam int PORT_W  = 16;
  localparam int PAIR_W  = AIDX_W + PORT_W;
  localparam int PAIR_DEPTH = 2 ** PAIR_W;
  localparam int COUNT_W = 18;
  localparam int ADDR_W  = 32;
  localparam int ACNT_W  = 3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_COUNT = CFG_IDX_W'(1);

  typedef enum logic {
    OP_FETCH = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_OUTSIDE    = 2'd2,
    ST_NOT_IN_USE = 2'd3
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] req_address;
    logic [PORT_W-1:0] req_port;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [ADDR_W-1:0]  out_address;
    logic [PORT_W-1:0]  out_port;
    logic [COUNT_W-1:0] free_count;
    logic [COUNT_W-1:0] used_count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic start;   // latch request, launch memory reads
    logic finish;  // commit update, load result register
  } dp_cmd_t;

endpackage

// ===== rtl/sppa_ram.sv =====
// generic single-write, single-read ram with registered read data
module sppa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sppa_ctrl.sv =====
// controller: item sequencing and result handshake
module sppa_ctrl
  import sppa_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // result register can take a new item this cycle
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/sppa_dp.sv =====
// datapath: pool pointers, returned ring, in-use bitmap and result register
module sppa_dp
  import sppa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  input  in_item_t              in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output out_item_t             out_data
);

  logic [ADDR_W-1:0]  base_r;
  logic [ACNT_W-1:0]  acount_r;
  logic [FIDX_W-1:0]  fresh_idx_r, fresh_idx_nxt;
  logic [PORT_W-1:0]  fresh_port_r, fresh_port_nxt;
  logic [PAIR_W-1:0]  head_r, head_nxt;
  logic [PAIR_W-1:0]  fill_r, fill_nxt;
  logic [COUNT_W-1:0] total_r, total_nxt;

  op_t               q_op_r;
  logic [AIDX_W-1:0] q_aidx_r;
  logic [PORT_W-1:0] q_port_r;
  logic              q_in_range_r;
  logic              q_handed_r;
  out_item_t         out_data_r, out_data_nxt;

  logic [FIDX_W-1:0]  naddr;
  logic [COUNT_W-1:0] pool_size;
  logic [ADDR_W-1:0]  offset;
  logic [AIDX_W-1:0]  in_aidx;
  logic               in_range;
  logic               handed;
  logic               rebuild;

  logic              bit_we, bit_wdata, bit_rdata;
  logic [PAIR_W-1:0] bit_waddr;
  logic              ring_we;
  logic [PAIR_W-1:0] ring_waddr, ring_wdata, ring_rdata;

  logic              got;
  logic [AIDX_W-1:0] g_aidx;
  logic [PORT_W-1:0] g_port;
  logic [PORT_W:0]   port_inc;

  assign naddr = ({{(32-ACNT_W){1'b0}}, acount_r} > 32'(ADDR_MAX)) ?
                 FIDX_W'(ADDR_MAX) : FIDX_W'(acount_r);
  assign pool_size = COUNT_W'(32'(naddr) * PORT_CNT);

  // request decode at accept
  assign offset   = in_data.req_address - base_r;
  assign in_aidx  = offset[AIDX_W-1:0];
  assign in_range = (offset < 32'(naddr)) && (in_data.req_port >= PORT_W'(PORT_MIN)) &&
                    ({1'b0, in_data.req_port} < (PORT_W+1)'(PORT_LIMIT));
  // a pair behind the fresh pointer has had its bitmap bit written since rebuild
  assign handed   = (FIDX_W'(in_aidx) < fresh_idx_r) ||
                    ((FIDX_W'(in_aidx) == fresh_idx_r) && (in_data.req_port < fresh_port_r));

  assign rebuild  = cfg_we && ((cfg_index == CFG_BASE_ADDRESS) ||
                               (cfg_index == CFG_ADDRESS_COUNT));

  sppa_ram #(.WIDTH(1), .DEPTH(PAIR_DEPTH)) u_bitmap (
    .clk   (clk),
    .we    (bit_we),
    .waddr (bit_waddr),
    .wdata (bit_wdata),
    .re    (cmd.start),
    .raddr ({in_aidx, in_data.req_port}),
    .rdata (bit_rdata)
  );

  sppa_ram #(.WIDTH(PAIR_W), .DEPTH(PAIR_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .re    (cmd.start),
    .raddr (head_r),
    .rdata (ring_rdata)
  );

  always_comb begin
    fresh_idx_nxt  = fresh_idx_r;
    fresh_port_nxt = fresh_port_r;
    head_nxt       = head_r;
    fill_nxt       = fill_r;
    total_nxt      = total_r;
    out_data_nxt   = out_data_r;
    bit_we         = 1'b0;
    bit_waddr      = {q_aidx_r, q_port_r};
    bit_wdata      = 1'b0;
    ring_we        = 1'b0;
    ring_waddr     = head_r + fill_r;
    ring_wdata     = {q_aidx_r, q_port_r};
    got            = 1'b0;
    g_aidx         = fresh_idx_r[AIDX_W-1:0];
    g_port         = fresh_port_r;
    port_inc       = {1'b0, fresh_port_r} + (PORT_W+1)'(1);

    if (cmd.finish) begin
      out_data_nxt.status      = ST_OK;
      out_data_nxt.out_address = '0;
      out_data_nxt.out_port    = '0;
      if (q_op_r == OP_FETCH) begin
        if ((PORT_CNT != 0) && (fresh_idx_r < naddr)) begin
          got = 1'b1;
          if (port_inc >= (PORT_W+1)'(PORT_LIMIT)) begin
            fresh_port_nxt = PORT_W'(PORT_MIN);
            fresh_idx_nxt  = fresh_idx_r + FIDX_W'(1);
          end else begin
            fresh_port_nxt = port_inc[PORT_W-1:0];
          end
        end else if ((fill_r != '0) && (PORT_CNT != 0)) begin
          got      = 1'b1;
          g_aidx   = ring_rdata[PAIR_W-1:PORT_W];
          g_port   = ring_rdata[PORT_W-1:0];
          head_nxt = head_r + PAIR_W'(1);
          fill_nxt = fill_r - PAIR_W'(1);
        end
        if (got) begin
          bit_we    = 1'b1;
          bit_waddr = {g_aidx, g_port};
          bit_wdata = 1'b1;
          total_nxt = total_r + COUNT_W'(1);
          out_data_nxt.out_address = base_r + ADDR_W'(g_aidx);
          out_data_nxt.out_port    = g_port;
        end else begin
          out_data_nxt.status = ST_EMPTY;
        end
      end else begin
        if (!q_in_range_r) begin
          out_data_nxt.status = ST_OUTSIDE;
        end else if (!(q_handed_r && bit_rdata)) begin
          out_data_nxt.status = ST_NOT_IN_USE;
        end else begin
          bit_we    = 1'b1;
          total_nxt = total_r - COUNT_W'(1);
          ring_we   = 1'b1;
          fill_nxt  = fill_r + PAIR_W'(1);
        end
      end
      out_data_nxt.used_count = total_nxt;
      out_data_nxt.free_count = pool_size - total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r       <= '0;
      acount_r     <= ACNT_W'(1);
      fresh_idx_r  <= '0;
      fresh_port_r <= PORT_W'(PORT_MIN);
      head_r       <= '0;
      fill_r       <= '0;
      total_r      <= '0;
    end else if (rebuild) begin
      if (cfg_index == CFG_BASE_ADDRESS) begin
        base_r <= cfg_wdata[ADDR_W-1:0];
      end else begin
        acount_r <= cfg_wdata[ACNT_W-1:0];
      end
      fresh_idx_r  <= '0;
      fresh_port_r <= PORT_W'(PORT_MIN);
      head_r       <= '0;
      fill_r       <= '0;
      total_r      <= '0;
    end else begin
      fresh_idx_r  <= fresh_idx_nxt;
      fresh_port_r <= fresh_port_nxt;
      head_r       <= head_nxt;
      fill_r       <= fill_nxt;
      total_r      <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q_op_r       <= in_data.op;
      q_aidx_r     <= in_aidx;
      q_port_r     <= in_data.req_port;
      q_in_range_r <= in_range;
      q_handed_r   <= handed;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_data = out_data_r;

endmodule

// ===== rtl/source_port_pool_allocator_core.sv =====
// Source address/port pool allocator. Each item is a fetch or a free and yields
// exactly one result item. The accept cycle launches the synchronous reads of the
// in-use bitmap and the returned-pair ring; the execute state then commits the
// update and loads the result register once that register is free, holding while
// a stalled result occupies it. The next item is taken only after the commit, so
// one item is in flight at a time. A finished result may wait in its register
// while the following item is accepted. No clearing pass runs after reset or a
// register write: an in-use bit counts only for pairs the fresh-pair pointer has
// already passed, so stale bitmap contents are never seen.
module source_port_pool_allocator_core
  import sppa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t cmd;

  sppa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  sppa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/sppa_checker.sv =====
// port-level checker for the allocator, bound to the top level
`include "source_port_pool_allocator_core_defines.svh"

module sppa_checker
  import sppa_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // one item in flight: an accepted item blocks the next cycle
  `SPPA_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall)

  // failed operations hand out nothing
  `SPPA_ASSERT_NOW(a_err_zero_pair, out_valid && (out_data.status != ST_OK),
                   (out_data.out_address == '0) && (out_data.out_port == '0))

  // an empty pool reports no free pairs
  `SPPA_ASSERT_NOW(a_empty_no_free, out_valid && (out_data.status == ST_EMPTY),
                   out_data.free_count == '0)

  // a stalled result holds
  `SPPA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind source_port_pool_allocator_core sppa_checker u_sppa_checker (.*);
